// File: rtl/arsg_pkg.sv
// shared types and constants for the annulus row span generator
// depends on nothing; used by arsg_root_cell and the top level
package arsg_pkg;

  localparam int ROW_W  = 11;
  localparam int RAD_W  = 10;
  localparam int SQ_W   = 2 * RAD_W;
  localparam int ROOT_W = RAD_W;
  localparam int ROOTS  = ROOT_W;
  localparam int CNT_W  = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_INNER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER = 1'b1;

  localparam logic [CNT_W-1:0] SPAN_NONE = 2'd0;
  localparam logic [CNT_W-1:0] SPAN_ONE  = 2'd1;
  localparam logic [CNT_W-1:0] SPAN_TWO  = 2'd2;

  // one row on its way down the root chain, outer and inner lanes side by side
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic              out_ok;
    logic              in_hit;
    logic [SQ_W-1:0]   rem_o;
    logic [SQ_W-1:0]   rem_i;
    logic [ROOT_W-1:0] root_o;
    logic [ROOT_W-1:0] root_i;
  } arsg_pipe_t;

endpackage

// File: rtl/arsg_root_cell.sv
// one cell of the integer square root chain: settles root bit BIT for both lanes
// depends on arsg_pkg
module arsg_root_cell #(
  parameter int BIT = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_vld,
  input  arsg_pkg::arsg_pipe_t up_d,
  output logic                 up_rdy,
  output logic                 dn_vld,
  output arsg_pkg::arsg_pipe_t dn_d,
  input  logic                 dn_rdy
);
  import arsg_pkg::*;

  localparam logic [SQ_W:0]   STEP    = (SQ_W+1)'(1) << (2 * BIT);
  localparam logic [ROOT_W-1:0] ROOT_BIT = ROOT_W'(1) << BIT;

  logic       vld_r;
  arsg_pipe_t d_r;
  arsg_pipe_t d_nxt;

  // (p + 2^b)^2 - p^2 = p*2^(b+1) + 2^(2b)
  function automatic logic [SQ_W+ROOT_W-1:0] lane_step(input logic [SQ_W-1:0] rem,
                                                        input logic [ROOT_W-1:0] root);
    logic [SQ_W:0] trial;
    logic          fit;
    trial = ((SQ_W+1)'(root) << (BIT + 1)) + STEP;
    fit   = {1'b0, rem} >= trial;
    if (fit) begin
      lane_step = {rem - trial[SQ_W-1:0], root | ROOT_BIT};
    end else begin
      lane_step = {rem, root};
    end
  endfunction

  always_comb begin
    d_nxt = up_d;
    {d_nxt.rem_o, d_nxt.root_o} = lane_step(up_d.rem_o, up_d.root_o);
    {d_nxt.rem_i, d_nxt.root_i} = lane_step(up_d.rem_i, up_d.root_i);
  end

  assign up_rdy = !vld_r || dn_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      d_r <= d_nxt;
    end
  end

  assign dn_vld = vld_r;
  assign dn_d   = d_r;

endmodule

// File: rtl/annulus_row_span_generator_unit.sv
// top level of the annulus row span generator: squares, root cell chain, span output
// depends on arsg_pkg and arsg_root_cell
// Each row offset request gives one result with the spans of columns whose squared
// distance lies in (inner^2, outer^2]. It takes one row per cycle unless the output
// stalls; a row passes the input register, squaring, radicand preparation, ten square
// root cells (one root bit each, both roots in parallel) and the output register. The
// root chain sets the row-to-row rate: each cell holds one row and hands it on every
// cycle unless stalled. Radii must be written through the cfg port while no row is in
// flight, which the block does not enforce; a radius above MAX_RADIUS is clamped to it.
module annulus_row_span_generator_unit #(
  parameter int MAX_RADIUS = 1023
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [arsg_pkg::IN_TDATA_W-1:0]       in_tdata,   // [10:0] row_offset
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [10:0] row_echo, [12:11] span_count, [23:13] first_low, [34:24] first_high,
  // [45:35] second_low, [56:46] second_high
  output logic [arsg_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [arsg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [arsg_pkg::RAD_W-1:0]            cfg_data
);
  import arsg_pkg::*;

  localparam int RAD_TOP = (1 << RAD_W) - 1;
  localparam int LIM     = (MAX_RADIUS > RAD_TOP) ? RAD_TOP : MAX_RADIUS;
  localparam logic [RAD_W-1:0] RAD_LIM = RAD_W'(LIM);

  // configuration
  logic [RAD_W-1:0] inner_r, outer_r;
  logic [SQ_W-1:0]  n2_r, m2_r;
  logic [RAD_W-1:0] ri, ro;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r <= '0;
      outer_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_INNER: inner_r <= cfg_data;
        REG_OUTER: outer_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ri = (inner_r > RAD_LIM) ? RAD_LIM : inner_r;
  assign ro = (outer_r > RAD_LIM) ? RAD_LIM : outer_r;

  // radius squares are registered from the clamped radius registers
  always_ff @(posedge clk) begin
    n2_r <= SQ_W'(ri) * SQ_W'(ri);
    m2_r <= SQ_W'(ro) * SQ_W'(ro);
  end

  // handshake chain
  logic v0_r, v1_r, v2_r;
  logic rdy0, rdy1, rdy2, rdy_out;
  logic       cell_v   [ROOTS+1];
  logic       cell_rdy [ROOTS+1];
  arsg_pipe_t cell_d   [ROOTS+1];

  assign rdy_out = !out_tvalid || out_tready;
  assign rdy2    = !v2_r || cell_rdy[0];
  assign rdy1    = !v1_r || rdy2;
  assign rdy0    = !v0_r || rdy1;
  assign in_tready = rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_tvalid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
    end
  end

  // stage 0: row register
  logic [ROW_W-1:0] s0_row_r;
  always_ff @(posedge clk) begin
    if (rdy0 && in_tvalid) begin
      s0_row_r <= in_tdata[ROW_W-1:0];
    end
  end

  // stage 1: row square
  logic [ROW_W-1:0] adz;
  logic [ROW_W-1:0] s1_row_r;
  logic [SQ_W:0]    s1_sq_r;

  assign adz = s0_row_r[ROW_W-1] ? (~s0_row_r + ROW_W'(1)) : s0_row_r;

  always_ff @(posedge clk) begin
    if (rdy1 && v0_r) begin
      s1_row_r <= s0_row_r;
      s1_sq_r  <= (SQ_W+1)'(adz) * (SQ_W+1)'(adz);
    end
  end

  // stage 2: radicands for the outer and inner roots
  arsg_pipe_t s2_r;
  arsg_pipe_t s2_nxt;

  always_comb begin
    s2_nxt.row    = s1_row_r;
    s2_nxt.out_ok = s1_sq_r <= {1'b0, m2_r};
    s2_nxt.in_hit = s1_sq_r <= {1'b0, n2_r};
    s2_nxt.rem_o  = m2_r - s1_sq_r[SQ_W-1:0];
    s2_nxt.rem_i  = n2_r - s1_sq_r[SQ_W-1:0];
    s2_nxt.root_o = '0;
    s2_nxt.root_i = '0;
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      s2_r <= s2_nxt;
    end
  end

  // root chain, most significant root bit first
  assign cell_v[0]        = v2_r;
  assign cell_d[0]        = s2_r;
  assign cell_rdy[ROOTS]  = rdy_out;

  for (genvar c = 0; c < ROOTS; c++) begin : g_cell
    arsg_root_cell #(
      .BIT(ROOTS - 1 - c)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .up_vld (cell_v[c]),
      .up_d   (cell_d[c]),
      .up_rdy (cell_rdy[c]),
      .dn_vld (cell_v[c+1]),
      .dn_d   (cell_d[c+1]),
      .dn_rdy (cell_rdy[c+1])
    );
  end

  // span assembly
  arsg_pipe_t       fin;
  logic [ROW_W-1:0] oh, ih1;
  logic [CNT_W-1:0] cnt;
  logic [ROW_W-1:0] f_lo, f_hi, s_lo, s_hi;
  logic             out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  assign fin = cell_d[ROOTS];
  assign oh  = ROW_W'(fin.root_o);
  assign ih1 = ROW_W'(fin.root_i) + ROW_W'(1);

  always_comb begin
    cnt  = SPAN_NONE;
    f_lo = '0;
    f_hi = '0;
    s_lo = '0;
    s_hi = '0;
    if (fin.out_ok) begin
      if (!fin.in_hit) begin
        cnt  = SPAN_ONE;
        f_lo = -oh;
        f_hi = oh;
      end else if (fin.root_i < fin.root_o) begin
        cnt  = SPAN_TWO;
        f_lo = -oh;
        f_hi = -ih1;
        s_lo = ih1;
        s_hi = oh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (rdy_out) begin
      out_tvalid_r <= cell_v[ROOTS];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && cell_v[ROOTS]) begin
      out_tdata_r <= OUT_TDATA_W'({s_hi, s_lo, f_hi, f_lo, cnt, fin.row});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // input only backs up when the whole chain is full behind a stalled result
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while pipeline has room");

  a_single_span_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[12:11] == SPAN_ONE) |->
      (out_tdata[23:13] == (~out_tdata[34:24] + 11'd1)))
    else $error("single span not symmetric");

  a_no_span_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[12:11] == SPAN_NONE) |-> (out_tdata[56:13] == '0))
    else $error("empty result carries span data");

  a_two_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[12:11] == SPAN_TWO) |->
      (!out_tdata[45] && (out_tdata[45:35] <= out_tdata[56:46])))
    else $error("second span out of order");

endmodule
